// File: design/cpb_pkg.sv
`default_nettype none
package cpb_pkg;

  localparam int ACT_DEPTH    = 4096;
  localparam int WEIGHT_DEPTH = 4096;
  localparam int ACT_AW       = $clog2(ACT_DEPTH);
  localparam int WGT_AW       = $clog2(WEIGHT_DEPTH);
  localparam int ACC_W        = 48;
  localparam int AIDX_W       = 24;
  localparam int WIDX_W       = 20;

  localparam logic [1:0] FUNC_WR_WEIGHT = 2'd0;
  localparam logic [1:0] FUNC_WR_ACT    = 2'd1;
  localparam logic [1:0] FUNC_COMPUTE   = 2'd2;

  localparam logic [3:0] REG_IN_CH  = 4'd0;
  localparam logic [3:0] REG_IN_H   = 4'd1;
  localparam logic [3:0] REG_IN_W   = 4'd2;
  localparam logic [3:0] REG_OUT_CH = 4'd3;
  localparam logic [3:0] REG_OUT_H  = 4'd4;
  localparam logic [3:0] REG_OUT_W  = 4'd5;
  localparam logic [3:0] REG_KSIDE  = 4'd6;
  localparam logic [3:0] REG_PAD    = 4'd7;

  typedef struct packed {
    logic [1:0]         func;
    logic [11:0]        address;
    logic signed [15:0] value;
    logic [5:0]         out_channel;
    logic [5:0]         out_row;
    logic [5:0]         out_col;
  } item_t;

  typedef struct packed {
    logic signed [15:0] conv_value;
    logic               saturated;
    logic               bad_coordinate;
  } result_t;

  typedef struct packed {
    logic [6:0] input_channels;
    logic [6:0] input_height;
    logic [6:0] input_width;
    logic [2:0] kernel_side;
    logic [1:0] pad_border;
  } cfg_t;

  typedef enum logic [1:0] {
    CMD_WR_WEIGHT = 2'd0,
    CMD_WR_ACT    = 2'd1,
    CMD_CALC      = 2'd2,
    CMD_BAD       = 2'd3
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [11:0]        address;
    logic signed [15:0] value;
    logic [5:0]         out_channel;
    logic [5:0]         out_row;
    logic [5:0]         out_col;
  } cmd_t;

endpackage
`default_nettype wire

// File: design/conv2d_padded_with_bias.sv
`default_nettype none
// Stride-1 2D convolution with zero padding and bias, Q8.8.
// Input channel: a queue port. A word is taken when push is high and full is
// low. func 0 writes a weight word, 1 writes an activation word, 2 asks for
// one output element, 3 is dropped. A two-word command queue sits behind the
// port, so words are taken while the engine is busy.
// Result channel: a queue port. The result is on result while empty is low
// and is taken when pop is high. While a result waits, writes still run and
// the queue keeps filling; the next result waits in the engine.
// Configuration: cfg_valid/cfg_ready (always ready), cfg_index selects the
// register, writes with an index past the list are dropped.
// Sequence: a store write is done in the idle state. An output element runs
// one multiply-accumulate per cycle from the two store read ports after the
// setup states SETUP1 to SETUP3, then the bias term, a 2-stage drain and the
// rounding in the finish state. A bad coordinate is answered from the idle state.
// Reset (rst, synchronous): registers to defaults, queues empty. Store
// contents are undefined until written.
module conv2d_padded_with_bias (
  input  wire              clk,
  input  wire              rst,
  input  wire              push,
  output logic             full,
  input  cpb_pkg::item_t   item,
  output logic             empty,
  input  wire              pop,
  output cpb_pkg::result_t result,
  input  wire              cfg_valid,
  output logic             cfg_ready,
  input  wire [3:0]        cfg_index,
  input  wire [6:0]        cfg_data
);
  import cpb_pkg::*;

  cfg_t cfg;
  logic q_valid, q_take;
  cmd_t q_cmd;

  cpb_front u_front (
    .clk, .rst, .push, .full, .item, .cfg_valid, .cfg_ready, .cfg_index,
    .cfg_data, .cfg, .q_valid, .q_cmd, .q_take
  );

  cpb_back u_back (
    .clk, .rst, .cfg, .q_valid, .q_cmd, .q_take, .empty, .pop, .result
  );
endmodule
`default_nettype wire

// File: design/cpb_front.sv
`default_nettype none
module cpb_front (
  input  wire           clk,
  input  wire           rst,
  input  wire           push,
  output logic          full,
  input  cpb_pkg::item_t item,
  input  wire           cfg_valid,
  output logic          cfg_ready,
  input  wire [3:0]     cfg_index,
  input  wire [6:0]     cfg_data,
  output cpb_pkg::cfg_t cfg,
  output logic          q_valid,
  output cpb_pkg::cmd_t q_cmd,
  input  wire           q_take
);
  import cpb_pkg::*;

  logic [6:0] out_channels, out_height, out_width;
  cmd_t       slot [2];
  logic       rd_ptr, wr_ptr;
  logic [1:0] count;
  cmd_t       cmd_in;
  logic       enq, deq;

  assign cfg_ready = 1'b1;
  assign full      = (count == 2'd2);

  always_comb begin
    cmd_in.address     = item.address;
    cmd_in.value       = item.value;
    cmd_in.out_channel = item.out_channel;
    cmd_in.out_row     = item.out_row;
    cmd_in.out_col     = item.out_col;
    case (item.func)
      FUNC_WR_WEIGHT: cmd_in.kind = CMD_WR_WEIGHT;
      FUNC_WR_ACT:    cmd_in.kind = CMD_WR_ACT;
      default: begin
        if ({1'b0, item.out_channel} >= out_channels ||
            {1'b0, item.out_row} >= out_height ||
            {1'b0, item.out_col} >= out_width) begin
          cmd_in.kind = CMD_BAD;
        end else begin
          cmd_in.kind = CMD_CALC;
        end
      end
    endcase
  end

  assign enq     = push && !full && (item.func != 2'd3);
  assign deq     = q_take && q_valid;
  assign q_valid = (count != 2'd0);
  assign q_cmd   = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.input_channels <= 7'd1;
      cfg.input_height   <= 7'd8;
      cfg.input_width    <= 7'd8;
      out_channels       <= 7'd1;
      out_height         <= 7'd8;
      out_width          <= 7'd8;
      cfg.kernel_side    <= 3'd3;
      cfg.pad_border     <= 2'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_IN_CH:  cfg.input_channels <= cfg_data;
        REG_IN_H:   cfg.input_height   <= cfg_data;
        REG_IN_W:   cfg.input_width    <= cfg_data;
        REG_OUT_CH: out_channels       <= cfg_data;
        REG_OUT_H:  out_height         <= cfg_data;
        REG_OUT_W:  out_width          <= cfg_data;
        REG_KSIDE:  cfg.kernel_side    <= cfg_data[2:0];
        REG_PAD:    cfg.pad_border     <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (enq) slot[wr_ptr] <= cmd_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (enq) wr_ptr <= ~wr_ptr;
      if (deq) rd_ptr <= ~rd_ptr;
      case ({enq, deq})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: design/cpb_back.sv
`default_nettype none
module cpb_back (
  input  wire             clk,
  input  wire             rst,
  input  cpb_pkg::cfg_t   cfg,
  input  wire             q_valid,
  input  cpb_pkg::cmd_t   q_cmd,
  output logic            q_take,
  output logic            empty,
  input  wire             pop,
  output cpb_pkg::result_t result
);
  import cpb_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_SETUP1 = 8'b0000_0010,
    ST_SETUP2 = 8'b0000_0100,
    ST_SETUP3 = 8'b0000_1000,
    ST_RUN    = 8'b0001_0000,
    ST_BIAS   = 8'b0010_0000,
    ST_DRAIN  = 8'b0100_0000,
    ST_FINISH = 8'b1000_0000
  } state_t;

  state_t state;

  logic signed [15:0] act_mem [ACT_DEPTH];
  logic signed [15:0] wgt_mem [WEIGHT_DEPTH];

  logic [5:0]  oc;
  logic [5:0]  orow, ocol;
  logic [5:0]  kk;
  logic [13:0] hw;
  logic [12:0] kkic;
  logic signed [AIDX_W-1:0] rowstart, rowoff, chbase;
  logic signed [8:0] y0, x0;
  logic [6:0]  ch;
  logic [2:0]  kh, kw;
  logic [WIDX_W-1:0] widx;

  logic signed [8:0] y, x;
  logic signed [AIDX_W-1:0] aidx;
  logic inb, kw_last, kh_last, ch_last, issue, issue_bias;

  logic r_valid, r_bias, r_wok, r_aok;
  logic signed [15:0] w_q, a_q;
  logic p_valid;
  logic signed [32:0] prod;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] rsum, rq;
  logic out_valid;

  logic signed [15:0] wv;
  logic signed [16:0] av;

  assign empty = !out_valid;

  always_comb begin
    y       = y0 + $signed({6'b0, kh});
    x       = x0 + $signed({6'b0, kw});
    inb     = !y[8] && !x[8] && (y[7:0] < {1'b0, cfg.input_height}) &&
              (x[7:0] < {1'b0, cfg.input_width});
    aidx    = rowoff + AIDX_W'(x);
    kw_last = (kw == cfg.kernel_side - 3'd1);
    kh_last = (kh == cfg.kernel_side - 3'd1);
    ch_last = (ch == cfg.input_channels - 7'd1);
    issue      = (state == ST_RUN) || (state == ST_BIAS);
    issue_bias = (state == ST_BIAS);
    q_take  = 1'b0;
    if (state == ST_IDLE && q_valid) begin
      q_take = (q_cmd.kind != CMD_BAD) || !out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (q_take && q_cmd.kind == CMD_WR_WEIGHT) wgt_mem[q_cmd.address] <= q_cmd.value;
    if (q_take && q_cmd.kind == CMD_WR_ACT) act_mem[q_cmd.address] <= q_cmd.value;
  end

  always_ff @(posedge clk) begin
    w_q    <= wgt_mem[widx[WGT_AW-1:0]];
    a_q    <= act_mem[aidx[ACT_AW-1:0]];
    r_bias <= issue_bias;
    r_wok  <= (widx < WIDX_W'(WEIGHT_DEPTH));
    r_aok  <= inb && !aidx[AIDX_W-1] && (aidx < AIDX_W'(ACT_DEPTH));
  end

  always_comb begin
    wv = r_wok ? w_q : 16'sd0;
    if (r_bias) av = 17'sd256;
    else if (r_aok) av = {a_q[15], a_q};
    else av = 17'sd0;
  end

  always_ff @(posedge clk) begin
    prod <= wv * av;
  end

  always_comb begin
    rsum = acc + ACC_W'(128);
    rq   = rsum >>> 8;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      r_valid   <= 1'b0;
      p_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      r_valid <= issue;
      p_valid <= r_valid;
      if (pop && out_valid) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (q_take && q_cmd.kind == CMD_CALC) state <= ST_SETUP1;
          if (q_take && q_cmd.kind == CMD_BAD) out_valid <= 1'b1;
        end
        ST_SETUP1: state <= ST_SETUP2;
        ST_SETUP2: state <= ST_SETUP3;
        ST_SETUP3: state <= (kkic == 13'd0) ? ST_BIAS : ST_RUN;
        ST_RUN: begin
          if (kw_last && kh_last && ch_last) state <= ST_BIAS;
        end
        ST_BIAS: state <= ST_DRAIN;
        ST_DRAIN: begin
          if (!r_valid && !p_valid) state <= ST_FINISH;
        end
        ST_FINISH: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (p_valid) acc <= acc + ACC_W'(prod);
    case (state)
      ST_IDLE: begin
        oc   <= q_cmd.out_channel;
        orow <= q_cmd.out_row;
        ocol <= q_cmd.out_col;
        if (q_take && q_cmd.kind == CMD_BAD) begin
          result.conv_value     <= 16'sd0;
          result.saturated      <= 1'b0;
          result.bad_coordinate <= 1'b1;
        end
      end
      ST_SETUP1: begin
        kk       <= {3'b0, cfg.kernel_side} * {3'b0, cfg.kernel_side};
        hw       <= {7'b0, cfg.input_height} * {7'b0, cfg.input_width};
        y0       <= $signed({3'b0, orow}) - $signed({7'b0, cfg.pad_border});
        x0       <= $signed({3'b0, ocol}) - $signed({7'b0, cfg.pad_border});
        rowstart <= AIDX_W'($signed({3'b0, orow}) - $signed({7'b0, cfg.pad_border})) *
                    AIDX_W'($signed({2'b0, cfg.input_width}));
      end
      ST_SETUP2: kkic <= 13'({7'b0, kk} * {6'b0, cfg.input_channels});
      ST_SETUP3: begin
        widx   <= WIDX_W'(oc) * (WIDX_W'(kkic) + WIDX_W'(1));
        rowoff <= rowstart;
        chbase <= '0;
        ch     <= '0;
        kh     <= '0;
        kw     <= '0;
        acc    <= '0;
      end
      ST_RUN: begin
        widx <= widx + WIDX_W'(1);
        if (kw_last) begin
          kw <= '0;
          if (kh_last) begin
            kh     <= '0;
            ch     <= ch + 7'd1;
            chbase <= chbase + AIDX_W'(hw);
            rowoff <= chbase + AIDX_W'(hw) + rowstart;
          end else begin
            kh     <= kh + 3'd1;
            rowoff <= rowoff + AIDX_W'(cfg.input_width);
          end
        end else begin
          kw <= kw + 3'd1;
        end
      end
      ST_FINISH: begin
        if (!out_valid) begin
          result.bad_coordinate <= 1'b0;
          if (rq > ACC_W'(32767)) begin
            result.conv_value <= 16'sd32767;
            result.saturated  <= 1'b1;
          end else if (rq < -ACC_W'(32768)) begin
            result.conv_value <= -16'sd32768;
            result.saturated  <= 1'b1;
          end else begin
            result.conv_value <= rq[15:0];
            result.saturated  <= 1'b0;
          end
        end
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// File: design/cpb_checker.sv
`default_nettype none
module cpb_checker (
  input wire              clk,
  input wire              rst,
  input wire              empty,
  input wire              pop,
  input cpb_pkg::result_t result
);
  import cpb_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result present after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(result))
    else $error("waiting result changed");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    !empty && result.bad_coordinate |-> result.conv_value == 16'sd0 && !result.saturated)
    else $error("bad coordinate with data");

  a_sat_rail: assert property (@(posedge clk) disable iff (rst)
    !empty && result.saturated |->
      result.conv_value == 16'sd32767 || result.conv_value == -16'sd32768)
    else $error("saturated flag off rail");
endmodule

bind conv2d_padded_with_bias cpb_checker u_checker (
  .clk, .rst, .empty, .pop, .result
);
`default_nettype wire

// File: verif/conv2d_padded_with_bias_tb.sv
`timescale 1ns / 1ps
module conv2d_padded_with_bias_tb;
  import cpb_pkg::*;

  localparam logic [1:0] FUNC_NOP = 2'(CMD_BAD);
  localparam int DOG_LIMIT = 20000;
  localparam int SETTLE = 50;

  typedef struct {
    item_t word;
    bit    hold;
  } pending_t;

  logic    clk;
  logic    rst;
  logic    push;
  logic    full;
  item_t   item;
  logic    empty;
  logic    pop;
  result_t result;
  logic    cfg_valid;
  logic    cfg_ready;
  logic [3:0] cfg_index;
  logic [6:0] cfg_data;

  conv2d_padded_with_bias dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .item(item),
    .empty(empty), .pop(pop), .result(result), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  pending_t    send_q[$];
  result_t     conv_q[$];
  logic [15:0] wgt_mem[WEIGHT_DEPTH];
  logic [15:0] act_mem[ACT_DEPTH];
  bit          wgt_set[WEIGHT_DEPTH];
  bit          act_set[ACT_DEPTH];
  int unsigned regs[8];
  int          errors = 0;
  int          n_calc = 0;
  int          n_sat = 0;
  int          n_bad = 0;
  int          n_phase = 0;
  int          cyc = 0;
  int          dog = 0;
  bit          cfg_took = 0;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  function automatic bit stall_now();
    if (cyc % 3000 < 1000) return 0;
    return $urandom_range(99) < 8;
  endfunction

  function automatic result_t conv_expect(item_t w);
    result_t r;
    longint ic, ih, iw, k, pad, rl, base, acc, q, y, x, wi, ai, wv, av;
    r = '0;
    if (w.out_channel >= regs[3] || w.out_row >= regs[4] || w.out_col >= regs[5]) begin
      r.bad_coordinate = 1;
      return r;
    end
    ic = regs[0]; ih = regs[1]; iw = regs[2]; k = regs[6]; pad = regs[7];
    rl = k * k * ic + 1;
    base = w.out_channel * rl;
    acc = 0;
    for (longint ch = 0; ch < ic; ch++)
      for (longint kh = 0; kh < k; kh++)
        for (longint kw = 0; kw < k; kw++) begin
          y = w.out_row + kh - pad;
          x = w.out_col + kw - pad;
          wi = base + ch * k * k + kh * k + kw;
          wv = (wi < WEIGHT_DEPTH) ? longint'($signed(wgt_mem[wi])) : 0;
          av = 0;
          if (y >= 0 && y < ih && x >= 0 && x < iw) begin
            ai = ch * ih * iw + y * iw + x;
            av = (ai < ACT_DEPTH) ? longint'($signed(act_mem[ai])) : 0;
          end
          acc += wv * av;
        end
    wi = base + rl - 1;
    acc += ((wi < WEIGHT_DEPTH) ? longint'($signed(wgt_mem[wi])) : 0) * 256;
    q = (acc + 128) >>> 8;
    if (q > 32767) begin
      q = 32767;
      r.saturated = 1;
    end else if (q < -32768) begin
      q = -32768;
      r.saturated = 1;
    end
    r.conv_value = 16'(q);
    return r;
  endfunction

  function automatic logic [15:0] rand_val();
    if ($urandom_range(3) == 0) return 16'($urandom);
    return 16'(int'($urandom_range(1023)) - 512);
  endfunction

  task automatic queue_word(logic [1:0] f, int addr, logic [15:0] v, bit hold = 0);
    pending_t p;
    p.word = item_t'($urandom);
    p.word.func = f;
    p.word.address = 12'(addr);
    p.word.value = v;
    p.hold = hold;
    if (f == FUNC_WR_WEIGHT) wgt_set[addr] = 1;
    if (f == FUNC_WR_ACT) act_set[addr] = 1;
    send_q.push_back(p);
  endtask

  // writes every store entry the element reads that has not been written yet
  task automatic queue_calc(int oc, int row, int col, bit hold = 0);
    pending_t p;
    longint k, rl, base, y, x, wi, ai;
    if (oc < regs[3] && row < regs[4] && col < regs[5]) begin
      k = regs[6];
      rl = k * k * regs[0] + 1;
      base = oc * rl;
      for (longint ch = 0; ch < regs[0]; ch++)
        for (longint kh = 0; kh < k; kh++)
          for (longint kw = 0; kw < k; kw++) begin
            wi = base + ch * k * k + kh * k + kw;
            if (wi < WEIGHT_DEPTH && !wgt_set[wi]) queue_word(FUNC_WR_WEIGHT, wi, rand_val());
            y = row + kh - regs[7];
            x = col + kw - regs[7];
            if (y >= 0 && y < regs[1] && x >= 0 && x < regs[2]) begin
              ai = ch * regs[1] * regs[2] + y * regs[2] + x;
              if (ai < ACT_DEPTH && !act_set[ai]) queue_word(FUNC_WR_ACT, ai, rand_val());
            end
          end
      wi = base + rl - 1;
      if (wi < WEIGHT_DEPTH && !wgt_set[wi]) queue_word(FUNC_WR_WEIGHT, wi, rand_val());
    end
    p.word = item_t'($urandom);
    p.word.func = FUNC_COMPUTE;
    p.word.out_channel = 6'(oc);
    p.word.out_row = 6'(row);
    p.word.out_col = 6'(col);
    p.hold = hold;
    send_q.push_back(p);
  endtask

  task automatic drain();
    while (send_q.size() != 0 || conv_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic load_regs(int unsigned v[8]);
    for (int i = 0; i < 8; i++) begin
      @(negedge clk);
      cfg_valid <= 1;
      cfg_index <= 4'(i);
      cfg_data <= 7'(v[i]);
      do @(posedge clk); while (!cfg_ready);
      regs[i] = v[i];
      cfg_took = 1;
    end
    @(negedge clk);
    cfg_valid <= 0;
    n_phase++;
  endtask

  function automatic int lim64(int unsigned v);
    return (v == 0) ? 0 : ((v > 64) ? 63 : v - 1);
  endfunction

  task automatic random_words(int n);
    int r, oc, row, col, span;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 45) begin
        span = lim64(regs[3]);
        oc = $urandom_range(1) ? $urandom_range(span < 1 ? span : 1)
                               : span - $urandom_range(span < 1 ? span : 1);
        row = $urandom_range(9) == 0 ? $urandom_range(63) : $urandom_range(lim64(regs[4]));
        col = $urandom_range(9) == 0 ? $urandom_range(63) : $urandom_range(lim64(regs[5]));
        queue_calc(oc, row, col, i == n / 2);
      end else if (r < 80) begin
        queue_word($urandom_range(1) ? FUNC_WR_WEIGHT : FUNC_WR_ACT,
                   $urandom_range(4095), rand_val());
      end else if (r < 86) begin
        queue_word(FUNC_NOP, $urandom_range(4095), rand_val());
      end else begin
        queue_calc($urandom_range(63), $urandom_range(63), $urandom_range(63));
      end
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst) begin
      cyc++;
      dog++;
      if (push && !full) begin
        dog = 0;
        case (item.func)
          FUNC_WR_WEIGHT: wgt_mem[item.address] = item.value;
          FUNC_WR_ACT:    act_mem[item.address] = item.value;
          FUNC_COMPUTE:   conv_q.push_back(conv_expect(item));
          default: ;
        endcase
        void'(send_q.pop_front());
      end
      if (pop && !empty) begin
        dog = 0;
        if (conv_q.size() == 0) begin
          $display("%0t: result with none expected: got %p", $realtime, result);
          errors++;
        end else begin
          want = conv_q.pop_front();
          n_calc++;
          n_sat += want.saturated;
          n_bad += want.bad_coordinate;
          if (result.conv_value !== want.conv_value) begin
            $display("%0t: conv_value expected %0d got %0d", $realtime,
                     want.conv_value, result.conv_value);
            errors++;
          end
          if (result.saturated !== want.saturated) begin
            $display("%0t: saturated expected %b got %b", $realtime,
                     want.saturated, result.saturated);
            errors++;
          end
          if (result.bad_coordinate !== want.bad_coordinate) begin
            $display("%0t: bad_coordinate expected %b got %b", $realtime,
                     want.bad_coordinate, result.bad_coordinate);
            errors++;
          end
        end
      end
      if (cfg_took) begin
        dog = 0;
        cfg_took = 0;
      end
      if (dog >= DOG_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $realtime, DOG_LIMIT);
        $display("conv2d_padded_with_bias regression: fail");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    if (rst || send_q.size() == 0 || stall_now() ||
        (send_q[0].hold && conv_q.size() != 0)) begin
      push <= 0;
    end else begin
      push <= 1;
      item <= send_q[0].word;
    end
    pop <= !rst && !stall_now();
  end

  initial begin
    int unsigned ph[6][8];
    ph[0] = '{2, 5, 6, 3, 5, 6, 3, 1};
    ph[1] = '{1, 10, 10, 2, 12, 12, 7, 3};
    ph[2] = '{64, 1, 1, 64, 2, 2, 1, 0};
    ph[3] = '{2, 64, 64, 2, 64, 64, 1, 0};
    ph[4] = '{0, 127, 127, 127, 127, 127, 0, 3};
    ph[5] = '{3, 4, 4, 2, 6, 6, 2, 2};
    regs = '{1, 8, 8, 1, 8, 8, 3, 1};
    rst = 1;
    push = 0;
    pop = 0;
    item = '0;
    cfg_valid = 0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // default registers: corner element at full scale both signs
    for (int i = 0; i < 10; i++) queue_word(FUNC_WR_WEIGHT, i, 16'h7fff);
    foreach (ph[0][j]) ;
    queue_word(FUNC_WR_ACT, 0, 16'h7fff);
    queue_word(FUNC_WR_ACT, 1, 16'h7fff);
    queue_word(FUNC_WR_ACT, 8, 16'h7fff);
    queue_word(FUNC_WR_ACT, 9, 16'h7fff);
    queue_calc(0, 0, 0);
    foreach (send_q[j]) ;
    queue_word(FUNC_WR_WEIGHT, 4, 16'h8000);
    queue_word(FUNC_WR_WEIGHT, 5, 16'h8000);
    queue_word(FUNC_WR_WEIGHT, 7, 16'h8000);
    queue_word(FUNC_WR_WEIGHT, 8, 16'h8000);
    queue_calc(0, 0, 0);
    queue_calc(1, 0, 0, 1);
    queue_calc(0, 8, 0);
    queue_calc(0, 0, 8);
    queue_word(FUNC_NOP, 4095, 16'h7fff);
    random_words(22);
    drain();

    foreach (ph[p]) begin
      load_regs(ph[p]);
      random_words(28);
      drain();
    end

    $display("covered %0d register settings, %0d elements checked", n_phase + 1, n_calc);
    $display("  of which %0d saturated and %0d out of range", n_sat, n_bad);
    if (errors == 0) begin
      $display("conv2d_padded_with_bias regression: pass");
    end else begin
      $display("conv2d_padded_with_bias regression: fail");
    end
    $finish;
  end

endmodule
